/* sv/rti_pkg.sv */
// shared constants, register indexes and pipeline control type for the ray/triangle tester
package rti_pkg;

   // default coordinate format, signed q10.10
   localparam int COORD_BITS_DEF = 21;
   localparam int FRAC_BITS_DEF  = 10;

   // configuration port
   localparam int CSR_DATA_BITS  = 63;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERTEX   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EDGE_ONE = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EDGE_TWO = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NORMAL   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EPSILON  = 3'd4;

   // fixed result formats and limits
   localparam int EPS_BITS        = 20;
   localparam int T_CAP_BITS      = 40;
   localparam int DISP_LIMIT_BITS = 24;
   localparam int DIST_BITS       = 48;

   // control bits that travel with each beat
   typedef struct packed {
      logic valid;
      logic pass;
      logic back_side;
   } rti_ctl_type;

endpackage

/* sv/rti_front.sv */
// geometry stages: cross products, dot products, determinant and barycentric bound tests
module rti_front #(
   parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = rti_pkg::FRAC_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         adv,
   input  logic                                         in_valid,
   input  logic signed [COORD_BITS-1:0]                 org [3],
   input  logic signed [COORD_BITS-1:0]                 dir [3],
   input  logic signed [COORD_BITS-1:0]                 vtx [3],
   input  logic signed [COORD_BITS-1:0]                 edge_one [3],
   input  logic signed [COORD_BITS-1:0]                 edge_two [3],
   input  logic signed [COORD_BITS-1:0]                 nrm [3],
   input  logic [rti_pkg::EPS_BITS-1:0]                 eps,
   output rti_pkg::rti_ctl_type                         ctl_out,
   output logic signed [3*COORD_BITS+3-FRAC_BITS:0]     det_out,
   output logic signed [3*COORD_BITS+3-FRAC_BITS:0]     tn_out,
   output logic signed [COORD_BITS-1:0]                 org_out [3],
   output logic signed [COORD_BITS-1:0]                 dir_out [3]
);
   import rti_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int PW = 2*C+1-F;
   localparam int QW = 2*C+2-F;
   localparam int SW = 3*C+4-F;
   localparam int BW = EPS_BITS+F;
   localparam int XW = ((SW > BW+1) ? SW : BW+1) + 1;

   // stage a: ray-edge cross products and origin offset
   logic signed [PW-1:0]  pv_in [3];
   logic signed [QW-1:0]  qv_in [3];
   logic signed [C:0]     tv_in [3];
   logic signed [2*C+1:0] nd_in;
   rti_ctl_type           ctl_a_in;

   logic signed [PW-1:0]  pv_a_ff [3];
   logic signed [QW-1:0]  qv_a_ff [3];
   logic signed [C:0]     tv_a_ff [3];
   logic signed [C-1:0]   org_a_ff [3];
   logic signed [C-1:0]   dir_a_ff [3];
   rti_ctl_type           ctl_a_ff;

   for (genvar k = 0; k < 3; k++) begin : g_tv
      assign tv_in[k] = (C+1)'(org[k]) - (C+1)'(vtx[k]);
   end

   for (genvar k = 0; k < 3; k++) begin : g_cross
      localparam int I1 = (k+1) % 3;
      localparam int I2 = (k+2) % 3;
      logic signed [2*C-1:0] pa;
      logic signed [2*C-1:0] pb;
      logic signed [2*C:0]   pdiff;
      logic signed [2*C:0]   qa;
      logic signed [2*C:0]   qb;
      logic signed [2*C+1:0] qdiff;
      assign pa    = dir[I1] * edge_two[I2];
      assign pb    = dir[I2] * edge_two[I1];
      assign pdiff = (2*C+1)'(pa) - (2*C+1)'(pb);
      assign pv_in[k] = pdiff[2*C:F];
      assign qa    = tv_in[I1] * edge_one[I2];
      assign qb    = tv_in[I2] * edge_one[I1];
      assign qdiff = (2*C+2)'(qa) - (2*C+2)'(qb);
      assign qv_in[k] = qdiff[2*C+1:F];
   end

   // dir dot normal only decides the side flag
   logic signed [2*C-1:0] nm [3];
   for (genvar k = 0; k < 3; k++) begin : g_nd
      assign nm[k] = dir[k] * nrm[k];
   end
   assign nd_in = (2*C+2)'(nm[0]) + (2*C+2)'(nm[1]) + (2*C+2)'(nm[2]);

   always_comb begin
      ctl_a_in.valid     = in_valid;
      ctl_a_in.pass      = 1'b1;
      ctl_a_in.back_side = ~nd_in[2*C+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
      end else if (adv) begin
         ctl_a_ff <= ctl_a_in;
         pv_a_ff  <= pv_in;
         qv_a_ff  <= qv_in;
         tv_a_ff  <= tv_in;
         org_a_ff <= org;
         dir_a_ff <= dir;
      end
   end

   // stage b: dot product terms
   logic signed [SW-1:0] det_p_in [3];
   logic signed [SW-1:0] un_p_in [3];
   logic signed [SW-1:0] vn_p_in [3];
   logic signed [SW-1:0] tn_p_in [3];

   logic signed [SW-1:0] det_p_ff [3];
   logic signed [SW-1:0] un_p_ff [3];
   logic signed [SW-1:0] vn_p_ff [3];
   logic signed [SW-1:0] tn_p_ff [3];
   logic signed [C-1:0]  org_b_ff [3];
   logic signed [C-1:0]  dir_b_ff [3];
   rti_ctl_type          ctl_b_ff;

   for (genvar k = 0; k < 3; k++) begin : g_dot
      logic signed [C+PW-1:0] dp;
      logic signed [C+PW:0]   up;
      logic signed [C+QW-1:0] vp;
      logic signed [C+QW-1:0] tp;
      assign dp = edge_one[k] * pv_a_ff[k];
      assign up = tv_a_ff[k] * pv_a_ff[k];
      assign vp = dir_a_ff[k] * qv_a_ff[k];
      assign tp = edge_two[k] * qv_a_ff[k];
      assign det_p_in[k] = SW'(dp);
      assign un_p_in[k]  = SW'(up);
      assign vn_p_in[k]  = SW'(vp);
      assign tn_p_in[k]  = SW'(tp);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff <= '0;
      end else if (adv) begin
         ctl_b_ff <= ctl_a_ff;
         det_p_ff <= det_p_in;
         un_p_ff  <= un_p_in;
         vn_p_ff  <= vn_p_in;
         tn_p_ff  <= tn_p_in;
         org_b_ff <= org_a_ff;
         dir_b_ff <= dir_a_ff;
      end
   end

   // stage c: sum the dot product terms
   logic signed [SW-1:0] det_in, un_in, vn_in, tn_in;
   logic signed [SW-1:0] det_c_ff, un_c_ff, vn_c_ff, tn_c_ff;
   logic signed [C-1:0]  org_c_ff [3];
   logic signed [C-1:0]  dir_c_ff [3];
   rti_ctl_type          ctl_c_ff;

   assign det_in = det_p_ff[0] + det_p_ff[1] + det_p_ff[2];
   assign un_in  = un_p_ff[0] + un_p_ff[1] + un_p_ff[2];
   assign vn_in  = vn_p_ff[0] + vn_p_ff[1] + vn_p_ff[2];
   assign tn_in  = tn_p_ff[0] + tn_p_ff[1] + tn_p_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_c_ff <= '0;
      end else if (adv) begin
         ctl_c_ff <= ctl_b_ff;
         det_c_ff <= det_in;
         un_c_ff  <= un_in;
         vn_c_ff  <= vn_in;
         tn_c_ff  <= tn_in;
         org_c_ff <= org_b_ff;
         dir_c_ff <= dir_b_ff;
      end
   end

   // stage d: epsilon test, sign fold and bound tests
   logic signed [XW-1:0] det_x;
   logic signed [XW-1:0] bound_x;
   logic                 det_small;
   logic                 det_neg;
   logic signed [SW-1:0] det_abs_in, un_abs, vn_abs, tn_abs_in;
   logic signed [SW:0]   uv_sum;
   logic                 bounds_ok;
   rti_ctl_type          ctl_d_in;

   logic signed [SW-1:0] det_d_ff, tn_d_ff;
   logic signed [C-1:0]  org_d_ff [3];
   logic signed [C-1:0]  dir_d_ff [3];
   rti_ctl_type          ctl_d_ff;

   always_comb begin
      det_x      = XW'(det_c_ff);
      bound_x    = $signed(XW'({eps, F'(0)}));
      det_small  = (det_x <= bound_x) && (det_x >= -bound_x);
      det_neg    = det_c_ff[SW-1];
      det_abs_in = det_neg ? -det_c_ff : det_c_ff;
      un_abs     = det_neg ? -un_c_ff : un_c_ff;
      vn_abs     = det_neg ? -vn_c_ff : vn_c_ff;
      tn_abs_in  = det_neg ? -tn_c_ff : tn_c_ff;
      uv_sum     = (SW+1)'(un_abs) + (SW+1)'(vn_abs);
      bounds_ok  = !un_abs[SW-1] && (un_abs <= det_abs_in) && !vn_abs[SW-1] &&
                   (uv_sum <= (SW+1)'(det_abs_in)) && (tn_abs_in > SW'(0));
      ctl_d_in           = ctl_c_ff;
      ctl_d_in.pass      = ctl_c_ff.pass && !det_small && bounds_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_d_ff <= '0;
      end else if (adv) begin
         ctl_d_ff <= ctl_d_in;
         det_d_ff <= det_abs_in;
         tn_d_ff  <= tn_abs_in;
         org_d_ff <= org_c_ff;
         dir_d_ff <= dir_c_ff;
      end
   end

   assign ctl_out = ctl_d_ff;
   assign det_out = det_d_ff;
   assign tn_out  = tn_d_ff;
   assign org_out = org_d_ff;
   assign dir_out = dir_d_ff;

endmodule

/* sv/rti_div.sv */
// pipelined restoring divider: t = floor(tn * 2^frac / det), one quotient bit per stage
module rti_div #(
   parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = rti_pkg::FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  rti_pkg::rti_ctl_type                     ctl_in,
   input  logic signed [3*COORD_BITS+3-FRAC_BITS:0] det_in,
   input  logic signed [3*COORD_BITS+3-FRAC_BITS:0] tn_in,
   input  logic signed [COORD_BITS-1:0]             org_in [3],
   input  logic signed [COORD_BITS-1:0]             dir_in [3],
   output rti_pkg::rti_ctl_type                     ctl_out,
   output logic [rti_pkg::T_CAP_BITS:0]             quo_out,
   output logic                                     ovf_out,
   output logic                                     rem_nz_out,
   output logic signed [COORD_BITS-1:0]             org_out [3],
   output logic signed [COORD_BITS-1:0]             dir_out [3]
);
   import rti_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int SW = 3*C+4-F;
   localparam int DW = SW-1;
   localparam int NS = T_CAP_BITS+1;
   localparam int RW = DW+T_CAP_BITS+2;

   logic [RW-1:0]       rem_ff [NS+1];
   logic [DW-1:0]       den_ff [NS+1];
   logic [NS-1:0]       quo_ff [NS+1];
   logic                ovf_ff [NS+1];
   rti_ctl_type         ctl_ff [NS+1];
   logic signed [C-1:0] org_ff [NS+1][3];
   logic signed [C-1:0] dir_ff [NS+1][3];

   // entry stage: scale the numerator, flag a quotient of 2^(cap+1) or more
   logic [RW-1:0] rem0_in;
   logic          ovf_in;

   assign rem0_in = RW'(tn_in[DW-1:0]) << F;
   assign ovf_in  = rem0_in >= (RW'(det_in[DW-1:0]) << NS);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (adv) begin
         ctl_ff[0] <= ctl_in;
         rem_ff[0] <= rem0_in;
         den_ff[0] <= det_in[DW-1:0];
         quo_ff[0] <= '0;
         ovf_ff[0] <= ovf_in;
         org_ff[0] <= org_in;
         dir_ff[0] <= dir_in;
      end
   end

   // one compare and subtract per stage, most significant bit first
   for (genvar j = 1; j <= NS; j++) begin : g_bit
      localparam int K = NS - j;
      logic [RW-1:0] sh;
      logic          take;
      logic [RW-1:0] rem_in;
      logic [NS-1:0] quo_in;

      assign sh     = RW'(den_ff[j-1]) << K;
      assign take   = rem_ff[j-1] >= sh;
      assign rem_in = take ? (rem_ff[j-1] - sh) : rem_ff[j-1];
      assign quo_in = {quo_ff[j-1][NS-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[j] <= '0;
         end else if (adv) begin
            ctl_ff[j] <= ctl_ff[j-1];
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_ff[j-1];
            quo_ff[j] <= quo_in;
            ovf_ff[j] <= ovf_ff[j-1];
            org_ff[j] <= org_ff[j-1];
            dir_ff[j] <= dir_ff[j-1];
         end
      end
   end

   assign ctl_out    = ctl_ff[NS];
   assign quo_out    = quo_ff[NS];
   assign ovf_out    = ovf_ff[NS];
   assign rem_nz_out = |rem_ff[NS];
   assign org_out    = org_ff[NS];
   assign dir_out    = dir_ff[NS];

endmodule

/* sv/rti_back.sv */
// hit stages: t cap and epsilon test, hit point, squared distance and result register
module rti_back #(
   parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = rti_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  rti_pkg::rti_ctl_type             ctl_in,
   input  logic [rti_pkg::T_CAP_BITS:0]     quo_in,
   input  logic                             ovf_in,
   input  logic                             rem_nz_in,
   input  logic signed [COORD_BITS-1:0]     org_in [3],
   input  logic signed [COORD_BITS-1:0]     dir_in [3],
   input  logic [rti_pkg::EPS_BITS-1:0]     eps,
   output logic                             rsp_valid,
   output logic                             rsp_hit,
   output logic [rti_pkg::DIST_BITS-1:0]    rsp_dist_sq,
   output logic signed [COORD_BITS-1:0]     rsp_hit_x,
   output logic signed [COORD_BITS-1:0]     rsp_hit_y,
   output logic signed [COORD_BITS-1:0]     rsp_hit_z,
   output logic                             rsp_back_side
);
   import rti_pkg::*;

   localparam int C   = COORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int NS  = T_CAP_BITS+1;
   localparam int DPW = NS+1+C;
   localparam int DDW = DPW-F;
   localparam int EW  = DDW+1;
   localparam int DL  = DISP_LIMIT_BITS;
   localparam int QW2 = 2*(DL+1);
   localparam int SUMW = 2*DL+2;

   localparam logic signed [EW-1:0]  H_HI  = EW'((longint'(1) << (C-1)) - 1);
   localparam logic signed [EW-1:0]  H_LO  = ~H_HI;
   localparam logic signed [DDW-1:0] D_LIM = DDW'(longint'(1) << DL);
   localparam logic [SUMW-1:0]       D_MAX = SUMW'((longint'(1) << DIST_BITS) - 1);

   // stage e: cap t, test it against epsilon, scale the direction
   logic              capped;
   logic [NS-1:0]     tq_in;
   logic              t_ok;
   logic [NS-1:0]     eps_x;
   logic signed [DDW-1:0] disp_in [3];
   rti_ctl_type       ctl_e_in;

   logic signed [DDW-1:0] disp_e_ff [3];
   logic signed [C-1:0]   org_e_ff [3];
   rti_ctl_type           ctl_e_ff;

   always_comb begin
      capped        = ovf_in || quo_in[NS-1];
      tq_in         = capped ? (NS'(1) << T_CAP_BITS) : quo_in;
      eps_x         = NS'(eps);
      t_ok          = (tq_in > eps_x) || ((tq_in == eps_x) && !capped && rem_nz_in);
      ctl_e_in      = ctl_in;
      ctl_e_in.pass = ctl_in.pass && t_ok;
   end

   for (genvar k = 0; k < 3; k++) begin : g_disp
      logic signed [DPW-1:0] prod;
      assign prod       = $signed({1'b0, tq_in}) * dir_in[k];
      assign disp_in[k] = prod[DPW-1:F];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_e_ff <= '0;
      end else if (adv) begin
         ctl_e_ff  <= ctl_e_in;
         disp_e_ff <= disp_in;
         org_e_ff  <= org_in;
      end
   end

   // stage f: hit point with clamping, displacement squares
   logic signed [C-1:0]  hit_in [3];
   logic [QW2-1:0]       sq_in [3];
   logic [2:0]           big;
   logic                 dsat_in;

   logic signed [C-1:0]  hit_f_ff [3];
   logic [QW2-1:0]       sq_f_ff [3];
   logic                 dsat_f_ff;
   rti_ctl_type          ctl_f_ff;

   for (genvar k = 0; k < 3; k++) begin : g_hit
      logic signed [EW-1:0]  h;
      logic signed [DL:0]    ds;
      logic signed [QW2-1:0] sq;
      assign h  = EW'(disp_e_ff[k]) + EW'(org_e_ff[k]);
      assign hit_in[k] = (h > H_HI) ? H_HI[C-1:0] :
                         (h < H_LO) ? H_LO[C-1:0] : h[C-1:0];
      assign big[k] = (disp_e_ff[k] >= D_LIM) || (disp_e_ff[k] <= -D_LIM);
      assign ds = disp_e_ff[k][DL:0];
      assign sq = ds * ds;
      assign sq_in[k] = sq;
   end
   assign dsat_in = |big;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_f_ff <= '0;
      end else if (adv) begin
         ctl_f_ff  <= ctl_e_ff;
         hit_f_ff  <= hit_in;
         sq_f_ff   <= sq_in;
         dsat_f_ff <= dsat_in;
      end
   end

   // stage g: distance sum with saturation, result register, zero fields on a miss
   logic [SUMW-1:0]        dist_sum;
   logic [DIST_BITS-1:0]   dist_in;
   logic                   hit_flag_in;

   logic                   valid_ff;
   logic                   hit_ff;
   logic [DIST_BITS-1:0]   dist_ff;
   logic signed [C-1:0]    hx_ff, hy_ff, hz_ff;
   logic                   back_ff;

   always_comb begin
      dist_sum    = SUMW'(sq_f_ff[0]) + SUMW'(sq_f_ff[1]) + SUMW'(sq_f_ff[2]);
      hit_flag_in = ctl_f_ff.pass;
      if (!hit_flag_in) begin
         dist_in = '0;
      end else if (dsat_f_ff || (dist_sum > D_MAX)) begin
         dist_in = '1;
      end else begin
         dist_in = dist_sum[DIST_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= ctl_f_ff.valid;
         hit_ff   <= hit_flag_in;
         dist_ff  <= dist_in;
         hx_ff    <= hit_flag_in ? hit_f_ff[0] : '0;
         hy_ff    <= hit_flag_in ? hit_f_ff[1] : '0;
         hz_ff    <= hit_flag_in ? hit_f_ff[2] : '0;
         back_ff  <= hit_flag_in && ctl_f_ff.back_side;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_hit       = hit_ff;
   assign rsp_dist_sq   = dist_ff;
   assign rsp_hit_x     = hx_ff;
   assign rsp_hit_y     = hy_ff;
   assign rsp_hit_z     = hz_ff;
   assign rsp_back_side = back_ff;

endmodule

/* sv/ray_triangle_intersect.sv */
// top level: triangle registers, pipeline advance control and the three pipeline sections
//
// Ray/triangle hit tester. One ray beat (origin and direction, signed fixed point)
// enters on the req_ channel and one result beat leaves on the rsp_ channel for it,
// in order. A beat moves when valid is high and stall is low.
// The triangle (vertex, edge one, edge two, normal) and the epsilon are written through
// the csr_ port, each write loading the register that csr_index selects. The user must
// write them only while no ray is in flight; the block itself does not enforce this.
// Throughput: one ray per cycle unless the result beat is stalled. Stages: 4 geometry,
// 1 divider entry, 41 divider (one quotient bit each, set by the 40-bit cap on t)
// and 3 hit/distance stages, the last being the result register.
// While the result register holds a beat that is stalled, the whole pipeline holds
// and req_stall is raised; nothing is dropped or repeated.
// Reset clears all pipeline valid bits and loads the register reset values
// (zero geometry, epsilon of one lsb); the block takes rays in the next cycle.
// A miss returns hit low and every other field zero.
module ray_triangle_intersect #(
   parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = rti_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [rti_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rti_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [COORD_BITS-1:0]         req_origin_x,
   input  logic signed [COORD_BITS-1:0]         req_origin_y,
   input  logic signed [COORD_BITS-1:0]         req_origin_z,
   input  logic signed [COORD_BITS-1:0]         req_dir_x,
   input  logic signed [COORD_BITS-1:0]         req_dir_y,
   input  logic signed [COORD_BITS-1:0]         req_dir_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hit,
   output logic [rti_pkg::DIST_BITS-1:0]        rsp_dist_sq,
   output logic signed [COORD_BITS-1:0]         rsp_hit_x,
   output logic signed [COORD_BITS-1:0]         rsp_hit_y,
   output logic signed [COORD_BITS-1:0]         rsp_hit_z,
   output logic                                 rsp_back_side
);
   import rti_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int SW = 3*C+4-F;
   localparam int VW = 3*C;

   // triangle registers
   logic [VW-1:0]       vertex_ff, edge_one_ff, edge_two_ff, normal_ff;
   logic [EPS_BITS-1:0] eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_ff   <= '0;
         edge_one_ff <= '0;
         edge_two_ff <= '0;
         normal_ff   <= '0;
         eps_ff      <= EPS_BITS'(1);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_VERTEX:   vertex_ff   <= csr_data[VW-1:0];
            CSR_EDGE_ONE: edge_one_ff <= csr_data[VW-1:0];
            CSR_EDGE_TWO: edge_two_ff <= csr_data[VW-1:0];
            CSR_NORMAL:   normal_ff   <= csr_data[VW-1:0];
            CSR_EPSILON:  eps_ff      <= csr_data[EPS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // unpack x, y, z
   logic signed [C-1:0] vtx [3];
   logic signed [C-1:0] e1 [3];
   logic signed [C-1:0] e2 [3];
   logic signed [C-1:0] nrm [3];
   logic signed [C-1:0] org [3];
   logic signed [C-1:0] dir [3];

   for (genvar k = 0; k < 3; k++) begin : g_unpack
      assign vtx[k] = vertex_ff[k*C +: C];
      assign e1[k]  = edge_one_ff[k*C +: C];
      assign e2[k]  = edge_two_ff[k*C +: C];
      assign nrm[k] = normal_ff[k*C +: C];
   end

   assign org[0] = req_origin_x;
   assign org[1] = req_origin_y;
   assign org[2] = req_origin_z;
   assign dir[0] = req_dir_x;
   assign dir[1] = req_dir_y;
   assign dir[2] = req_dir_z;

   // whole pipeline moves unless a finished beat is held
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   rti_ctl_type          ctl_fd;
   logic signed [SW-1:0] det_fd, tn_fd;
   logic signed [C-1:0]  org_fd [3];
   logic signed [C-1:0]  dir_fd [3];

   rti_front #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .org      (org),
      .dir      (dir),
      .vtx      (vtx),
      .edge_one (e1),
      .edge_two (e2),
      .nrm      (nrm),
      .eps      (eps_ff),
      .ctl_out  (ctl_fd),
      .det_out  (det_fd),
      .tn_out   (tn_fd),
      .org_out  (org_fd),
      .dir_out  (dir_fd)
   );

   rti_ctl_type          ctl_db;
   logic [T_CAP_BITS:0]  quo_db;
   logic                 ovf_db;
   logic                 rem_nz_db;
   logic signed [C-1:0]  org_db [3];
   logic signed [C-1:0]  dir_db [3];

   rti_div #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .ctl_in     (ctl_fd),
      .det_in     (det_fd),
      .tn_in      (tn_fd),
      .org_in     (org_fd),
      .dir_in     (dir_fd),
      .ctl_out    (ctl_db),
      .quo_out    (quo_db),
      .ovf_out    (ovf_db),
      .rem_nz_out (rem_nz_db),
      .org_out    (org_db),
      .dir_out    (dir_db)
   );

   rti_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .ctl_in        (ctl_db),
      .quo_in        (quo_db),
      .ovf_in        (ovf_db),
      .rem_nz_in     (rem_nz_db),
      .org_in        (org_db),
      .dir_in        (dir_db),
      .eps           (eps_ff),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit),
      .rsp_dist_sq   (rsp_dist_sq),
      .rsp_hit_x     (rsp_hit_x),
      .rsp_hit_y     (rsp_hit_y),
      .rsp_hit_z     (rsp_hit_z),
      .rsp_back_side (rsp_back_side)
   );

`ifndef NO_ASSERTIONS
   // input is held back only by a stalled result beat
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result beat");

   // a miss carries no distance, point or side
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> ((rsp_dist_sq == '0) && !rsp_back_side &&
      (rsp_hit_x == '0) && (rsp_hit_y == '0) && (rsp_hit_z == '0)))
      else $error("miss result with non-zero fields");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for the ray/triangle hit tester: directed rows, then aimed and random rays
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rti_pkg::*;

   localparam int CB   = COORD_BITS_DEF;
   localparam int FB   = FRAC_BITS_DEF;
   localparam int ONE  = 1 << FB;
   localparam int SETTLE_CYCLES = 60;

   typedef struct packed {
      logic signed [CB-1:0] ox, oy, oz, dx, dy, dz;
      logic                 typed_miss;
   } ray_row_type;

   typedef struct packed {
      logic                 hit;
      logic [DIST_BITS-1:0] dist_sq;
      logic signed [CB-1:0] hx, hy, hz;
      logic                 back_side;
   } hit_result_type;

   logic clock, reset;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CB-1:0] req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   logic signed [CB-1:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit, rsp_back_side;
   logic [DIST_BITS-1:0] rsp_dist_sq;
   logic signed [CB-1:0] rsp_hit_x, rsp_hit_y, rsp_hit_z;

   // triangle registers as last written
   logic [CSR_DATA_BITS-1:0] tri_vertex, tri_edge_one, tri_edge_two, tri_normal;
   logic [EPS_BITS-1:0]      tri_eps;

   hit_result_type pending_hits[$];
   int errors = 0;
   int hits_seen = 0, misses_seen = 0, rays_sent = 0;
   int idle_pct = 0, stall_pct = 0;
   bit hold_request = 1'b0;

   ray_triangle_intersect u_top (.*);

   // clock and timeout
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

   // fixed point helpers
   function automatic void unpack_vec(input logic [CSR_DATA_BITS-1:0] p, output longint r[3]);
      for (int k = 0; k < 3; k++) r[k] = longint'($signed(p[k*CB +: CB]));
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pack_vec(input longint x, y, z);
      logic [CB-1:0] a, b, c;
      a = x[CB-1:0];
      b = y[CB-1:0];
      c = z[CB-1:0];
      return {c, b, a};
   endfunction

   function automatic void cross_q(input longint a[3], input longint b[3], output longint r[3]);
      r[0] = (a[1]*b[2] - a[2]*b[1]) >>> FB;
      r[1] = (a[2]*b[0] - a[0]*b[2]) >>> FB;
      r[2] = (a[0]*b[1] - a[1]*b[0]) >>> FB;
   endfunction

   function automatic longint dot_q(input longint a[3], input longint b[3]);
      return a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
   endfunction

   // expected hit result of one ray against the current triangle
   function automatic hit_result_type intersect_ray(input ray_row_type ray);
      hit_result_type res;
      longint org[3], dir[3], vtx[3], e1[3], e2[3], nrm[3], pv[3], tv[3], qv[3];
      longint det, un, vn, tn, q, r, tq, eps, bound, disp, h;
      longint lo, hi;
      longint unsigned dist_acc;
      bit dsat;
      res = '0;
      lo = -(longint'(1) << (CB-1));
      hi = (longint'(1) << (CB-1)) - 1;
      org = '{longint'(ray.ox), longint'(ray.oy), longint'(ray.oz)};
      dir = '{longint'(ray.dx), longint'(ray.dy), longint'(ray.dz)};
      unpack_vec(tri_vertex, vtx);
      unpack_vec(tri_edge_one, e1);
      unpack_vec(tri_edge_two, e2);
      unpack_vec(tri_normal, nrm);
      eps = longint'(tri_eps);
      cross_q(dir, e2, pv);
      det = dot_q(e1, pv);
      bound = eps << FB;
      if (det <= bound && det >= -bound) return res;
      for (int k = 0; k < 3; k++) tv[k] = org[k] - vtx[k];
      un = dot_q(tv, pv);
      cross_q(tv, e1, qv);
      vn = dot_q(dir, qv);
      tn = dot_q(e2, qv);
      if (det < 0) begin
         det = -det; un = -un; vn = -vn; tn = -tn;
      end
      if (un < 0 || un > det || vn < 0 || un + vn > det || tn <= 0) return res;
      // long division for the fractional bits of t, capped for huge t
      q = tn / det;
      r = tn % det;
      if (q >= (longint'(1) << (T_CAP_BITS - FB))) begin
         tq = longint'(1) << T_CAP_BITS;
         r = 0;
      end else begin
         tq = q;
         for (int i = 0; i < FB; i++) begin
            r = r << 1;
            tq = tq << 1;
            if (r >= det) begin
               r = r - det;
               tq = tq | 1;
            end
         end
      end
      if (!(tq > eps || (tq == eps && r != 0))) return res;
      dist_acc = 0;
      dsat = 1'b0;
      for (int k = 0; k < 3; k++) begin
         disp = (tq * dir[k]) >>> FB;
         h = org[k] + disp;
         if (h < lo) h = lo;
         if (h > hi) h = hi;
         if (k == 0) res.hx = h[CB-1:0];
         if (k == 1) res.hy = h[CB-1:0];
         if (k == 2) res.hz = h[CB-1:0];
         if (disp >= (longint'(1) << DISP_LIMIT_BITS) || disp <= -(longint'(1) << DISP_LIMIT_BITS))
            dsat = 1'b1;
         else
            dist_acc += longint'(disp * disp);
      end
      if (dsat || dist_acc > ((64'd1 << DIST_BITS) - 1)) dist_acc = (64'd1 << DIST_BITS) - 1;
      res.hit = 1'b1;
      res.dist_sq = dist_acc[DIST_BITS-1:0];
      res.back_side = (dot_q(dir, nrm) >= 0);
      return res;
   endfunction

   // receiver: random stalls, plus a long hold-off when asked
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // result beat checker
   always @(posedge clock) begin
      hit_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_hits.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            want = pending_hits.pop_front();
            if (rsp_hit) hits_seen++; else misses_seen++;
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0d got %0d", want.hit, rsp_hit); errors++;
            end
            if (rsp_dist_sq !== want.dist_sq) begin
               $error("dist_sq: expected %0d got %0d", want.dist_sq, rsp_dist_sq); errors++;
            end
            if (rsp_hit_x !== want.hx) begin
               $error("hit_x: expected %0d got %0d", want.hx, rsp_hit_x); errors++;
            end
            if (rsp_hit_y !== want.hy) begin
               $error("hit_y: expected %0d got %0d", want.hy, rsp_hit_y); errors++;
            end
            if (rsp_hit_z !== want.hz) begin
               $error("hit_z: expected %0d got %0d", want.hz, rsp_hit_z); errors++;
            end
            if (rsp_back_side !== want.back_side) begin
               $error("back_side: expected %0d got %0d", want.back_side, rsp_back_side);
               errors++;
            end
         end
      end
   end

   // one ray beat, entered at a falling edge, returns at a falling edge
   task automatic send_ray(input ray_row_type ray);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_origin_x <= ray.ox; req_origin_y <= ray.oy; req_origin_z <= ray.oz;
      req_dir_x <= ray.dx; req_dir_y <= ray.dy; req_dir_z <= ray.dz;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_hits.insert(pending_hits.size(),
                          ray.typed_miss ? hit_result_type'('0) : intersect_ray(ray));
      rays_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one register write; the caller drops the write enable after the last one
   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
      case (idx)
         CSR_VERTEX:   tri_vertex = data;
         CSR_EDGE_ONE: tri_edge_one = data;
         CSR_EDGE_TWO: tri_edge_two = data;
         CSR_NORMAL:   tri_normal = data;
         CSR_EPSILON:  tri_eps = data[EPS_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic load_triangle(input logic [CSR_DATA_BITS-1:0] v, e1, e2, n,
                                input logic [EPS_BITS-1:0] eps);
      csr_write(CSR_VERTEX, v);
      csr_write(CSR_EDGE_ONE, e1);
      csr_write(CSR_EDGE_TWO, e2);
      csr_write(CSR_NORMAL, n);
      csr_write(CSR_EPSILON, {{(CSR_DATA_BITS-EPS_BITS){1'b0}}, eps});
      csr_write_en <= 1'b0;
   endtask

   function automatic longint rand_coord(input int span);
      return longint'($urandom_range(2*span)) - span;
   endfunction

   // a ray aimed at a point in or near the triangle, random content otherwise
   function automatic ray_row_type make_ray();
      ray_row_type ray;
      logic [127:0] raw;
      longint vtx[3], e1[3], e2[3], tgt[3], org[3];
      int a, b, sel, shift;
      ray = '0;
      sel = $urandom_range(99);
      if (sel < 25) begin
         raw = {$urandom, $urandom, $urandom, $urandom};
         ray = ray_row_type'(raw[$bits(ray_row_type)-1:0]);
         ray.typed_miss = 1'b0;
      end else if (sel < 30) begin
         ray.ox = $urandom_range(1) ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
         ray.oy = $urandom_range(1) ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
         ray.oz = CB'($urandom);
         ray.dx = $urandom_range(1) ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
         ray.dy = $urandom_range(2) == 0 ? '0 : CB'($urandom);
         ray.dz = $urandom_range(1) ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
      end else begin
         unpack_vec(tri_vertex, vtx);
         unpack_vec(tri_edge_one, e1);
         unpack_vec(tri_edge_two, e2);
         a = $urandom_range(1300);
         b = $urandom_range(1300 - a);
         shift = $urandom_range(3);
         for (int k = 0; k < 3; k++) begin
            tgt[k] = vtx[k] + ((a*e1[k] + b*e2[k]) >>> FB);
            org[k] = tgt[k] + rand_coord(1 << 17);
         end
         ray.ox = org[0][CB-1:0]; ray.oy = org[1][CB-1:0]; ray.oz = org[2][CB-1:0];
         ray.dx = CB'((tgt[0] - org[0]) >>> shift);
         ray.dy = CB'((tgt[1] - org[1]) >>> shift);
         ray.dz = CB'((tgt[2] - org[2]) >>> shift);
         // now and then point the ray away, so t falls behind the origin
         if ($urandom_range(9) == 0) begin
            ray.dx = -ray.dx; ray.dy = -ray.dy; ray.dz = -ray.dz;
         end
      end
      return ray;
   endfunction

   task automatic run_phase(input int count, input int idle, input int stall, input bit press);
      idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         if (press && i == 20) hold_request = 1'b1;
         send_ray(make_ray());
      end
      drain_results();
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] rand_vec(input int span);
      return pack_vec(rand_coord(span), rand_coord(span), rand_coord(span));
   endfunction

   localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

   // rays against the zero triangle after reset: all misses
   ray_row_type reset_rows[5] = '{
      '{'0, '0, '0, '0, '0, '0, 1'b1},
      '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b1},
      '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b1},
      '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 1'b1},
      '{-21'sd1, -21'sd1, -21'sd1, 21'sd1, -21'sd1, 21'sd1, 1'b1}
   };

   // rays against a right isosceles triangle in the plane z = 5
   ray_row_type tri_rows[14] = '{
      '{'0, '0, '0, '0, '0, 21'(ONE), 1'b0},                     // straight through
      '{'0, '0, '0, '0, '0, '0, 1'b1},                           // zero direction
      '{'0, '0, '0, 21'(ONE), '0, '0, 1'b0},                     // parallel to plane
      '{-21'(ONE), -21'(ONE), '0, '0, '0, 21'(ONE), 1'b0},       // on the vertex, u=v=0
      '{21'(ONE), -21'(ONE), '0, '0, '0, 21'(ONE), 1'b0},        // far end of edge one
      '{'0, '0, '0, '0, '0, -21'(ONE), 1'b0},                    // triangle behind origin
      '{'0, '0, 21'(10*ONE), '0, '0, -21'(ONE), 1'b0},           // from the other side
      '{-21'(2*ONE), '0, '0, '0, '0, 21'(ONE), 1'b0},            // u below zero
      '{'0, '0, '0, 21'(ONE), 21'(ONE), 21'(ONE/4), 1'b0},       // u+v above one
      '{'0, '0, '0, '0, '0, 21'sd1, 1'b0},                       // tiny direction, huge t
      '{'0, '0, '0, '0, '0, CMAX, 1'b0},                         // longest direction
      '{CMAX, CMAX, CMIN, '0, '0, CMAX, 1'b0},
      '{'0, '0, 21'(5*ONE), '0, '0, 21'(ONE), 1'b0},             // origin on the plane
      '{'0, '0, 21'(5*ONE - 1), '0, '0, 21'(ONE), 1'b0}          // t just above zero
   };

   initial begin
      reset = 1'b1;
      tri_vertex = '0; tri_edge_one = '0; tri_edge_two = '0; tri_normal = '0;
      tri_eps = EPS_BITS'(1);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows
      foreach (reset_rows[i]) send_ray(reset_rows[i]);
      drain_results();
      load_triangle(pack_vec(-ONE, -ONE, 5*ONE), pack_vec(2*ONE, 0, 0),
                    pack_vec(0, 2*ONE, 0), pack_vec(0, 0, -ONE), EPS_BITS'(1));
      foreach (tri_rows[i]) send_ray(tri_rows[i]);
      drain_results();

      // random phases over several triangles and thresholds
      run_phase(200, 0, 0, 1'b0);
      load_triangle(rand_vec(1 << 16), rand_vec(1 << 16), rand_vec(1 << 16),
                    rand_vec(1 << 20), EPS_BITS'(0));
      run_phase(200, 49, 0, 1'b0);
      load_triangle(rand_vec(1 << 15), rand_vec(1 << 17), rand_vec(1 << 17),
                    rand_vec(1 << 10), 20'($urandom_range(64)));
      run_phase(200, 0, 49, 1'b1);
      load_triangle(rand_vec(1 << 16), rand_vec(1 << 16), rand_vec(1 << 16),
                    rand_vec(1 << 20), 20'($urandom_range(8)));
      run_phase(200, 20, 20, 1'b0);
      load_triangle(CSR_DATA_BITS'({$urandom, $urandom}),
                    CSR_DATA_BITS'({$urandom, $urandom}),
                    CSR_DATA_BITS'({$urandom, $urandom}),
                    CSR_DATA_BITS'({$urandom, $urandom}), {EPS_BITS{1'b1}});
      run_phase(100, 20, 20, 1'b0);
      load_triangle(pack_vec(CMAX, CMIN, CMAX), pack_vec(CMIN, CMAX, 0),
                    pack_vec(0, CMIN, CMAX), pack_vec(CMIN, CMIN, CMIN), EPS_BITS'(0));
      run_phase(100, 0, 0, 1'b0);
      load_triangle(rand_vec(1 << 14), rand_vec(1 << 16), rand_vec(1 << 16),
                    rand_vec(1 << 20), EPS_BITS'(1));
      run_phase(200, 20, 20, 1'b1);

      $display("rays sent: %0d, results checked: %0d hits and %0d misses",
               rays_sent, hits_seen, misses_seen);
      $display("seven triangle settings, epsilon from zero to full scale, four idling mixes");
      if (errors == 0 && pending_hits.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* ray_triangle_intersect.f */
sv/rti_pkg.sv
sv/rti_front.sv
sv/rti_div.sv
sv/rti_back.sv
sv/ray_triangle_intersect.sv
tb/sv/testbench.sv
